### sv/vgm_pkg.sv
// ----------------------------------------------------------------------------
// vgm_pkg
// shared types, constants and helpers of the volume gradient magnitude block
// ----------------------------------------------------------------------------
package vgm_pkg;

  localparam int MaxDim    = 64;
  localparam int DimW      = $clog2(MaxDim);
  localparam int SizeW     = 7;
  localparam int SampleW   = 16;
  localparam int GradW     = SampleW + 1;
  localparam int WinSlices = 5;
  localparam int ZW        = 3;
  localparam int AddrW     = ZW + 2 * DimW;
  localparam int WinDepth  = WinSlices * MaxDim * MaxDim;
  localparam int CntW      = 19;
  localparam int DiffW     = SampleW + 1;
  localparam int SumW      = 2 * DiffW;
  localparam int RemW      = GradW + 3;
  localparam int CfgIdxW   = 3;
  localparam int QDepth    = 4;

  localparam logic ReqSample = 1'b0;
  localparam logic ReqDrain  = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    RegSizeX  = 3'd0,
    RegSizeY  = 3'd1,
    RegSizeZ  = 3'd2,
    RegMinOn  = 3'd3,
    RegMinVal = 3'd4,
    RegMaxOn  = 3'd5,
    RegMaxVal = 3'd6
  } reg_idx_e;

  typedef enum logic [2:0] {
    BkIdle,
    BkRead,
    BkSquare,
    BkRoot,
    BkOut
  } back_state_e;

  typedef struct packed {
    logic [SizeW-1:0]          size_x;
    logic [SizeW-1:0]          size_y;
    logic [SizeW-1:0]          size_z;
    logic                      min_on;
    logic signed [SampleW-1:0] min_val;
    logic                      max_on;
    logic signed [SampleW-1:0] max_val;
  } cfg_t;

  typedef struct packed {
    logic                      wr;
    logic [AddrW-1:0]          addr;
    logic signed [SampleW-1:0] data;
    logic                      emit;
    logic                      last;
  } cmd_t;

  function automatic logic [SizeW-1:0] dim(input logic [SizeW-1:0] s);
    logic [SizeW-1:0] r;
    r = s;
    if (s < SizeW'(3)) r = SizeW'(3);
    if (s > SizeW'(MaxDim)) r = SizeW'(MaxDim);
    return r;
  endfunction

  function automatic logic [ZW-1:0] zadd(input logic [ZW-1:0] z, input logic [ZW-1:0] k);
    logic [ZW:0] s;
    s = {1'b0, z} + {1'b0, k};
    if (s >= (ZW+1)'(WinSlices)) s = s - (ZW+1)'(WinSlices);
    return s[ZW-1:0];
  endfunction

endpackage

### sv/vgm_ram.sv
// ----------------------------------------------------------------------------
// vgm_ram
// single port ram with registered read
// ----------------------------------------------------------------------------
module vgm_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### sv/vgm_front.sv
// ----------------------------------------------------------------------------
// vgm_front
// accepts words, tracks input and output counts and issues window commands
// ----------------------------------------------------------------------------
module vgm_front import vgm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      restart_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      full_i,
  output logic                      push_o,
  output cmd_t                      cmd_o
);

  logic [SizeW-1:0]   nx, ny, nz;
  logic [2*SizeW-1:0] slice;
  logic [3*SizeW-1:0] total_full;
  logic [CntW-1:0]    total, two_slice;
  logic [CntW-1:0]    in_cnt_q, in_cnt_d, out_cnt_q, out_cnt_d;
  logic [DimW-1:0]    ix_q, ix_d, iy_q, iy_d;
  logic [ZW-1:0]      iz_q, iz_d;
  logic               accept;

  assign nx         = dim(cfg_i.size_x);
  assign ny         = dim(cfg_i.size_y);
  assign nz         = dim(cfg_i.size_z);
  assign slice      = nx * ny;
  assign total_full = slice * nz;
  assign total      = total_full[CntW-1:0];
  assign two_slice  = CntW'({slice, 1'b0});

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    push_o    = 1'b0;
    cmd_o     = '0;
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    ix_d      = ix_q;
    iy_d      = iy_q;
    iz_d      = iz_q;
    if (accept) begin
      if (req_type_i == ReqSample) begin
        if (in_cnt_q < total) begin
          push_o     = 1'b1;
          cmd_o.wr   = 1'b1;
          cmd_o.addr = {iz_q, iy_q, ix_q};
          cmd_o.data = sample_i;
          cmd_o.emit = in_cnt_q >= two_slice;
          cmd_o.last = cmd_o.emit && (out_cnt_q == total - CntW'(1));
          in_cnt_d   = in_cnt_q + CntW'(1);
          if ({1'b0, ix_q} == nx - SizeW'(1)) begin
            ix_d = '0;
            if ({1'b0, iy_q} == ny - SizeW'(1)) begin
              iy_d = '0;
              iz_d = zadd(iz_q, ZW'(1));
            end else begin
              iy_d = iy_q + DimW'(1);
            end
          end else begin
            ix_d = ix_q + DimW'(1);
          end
          if (cmd_o.emit) out_cnt_d = out_cnt_q + CntW'(1);
        end
      end else begin
        if (in_cnt_q >= total && out_cnt_q < total) begin
          push_o     = 1'b1;
          cmd_o.emit = 1'b1;
          cmd_o.last = out_cnt_q == total - CntW'(1);
          out_cnt_d  = out_cnt_q + CntW'(1);
        end
      end
      if (cmd_o.last) begin
        in_cnt_d  = '0;
        out_cnt_d = '0;
        ix_d      = '0;
        iy_d      = '0;
        iz_d      = '0;
      end
    end
    if (restart_i) begin
      in_cnt_d  = '0;
      out_cnt_d = '0;
      ix_d      = '0;
      iy_d      = '0;
      iz_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      ix_q      <= '0;
      iy_q      <= '0;
      iz_q      <= '0;
    end else begin
      in_cnt_q  <= in_cnt_d;
      out_cnt_q <= out_cnt_d;
      ix_q      <= ix_d;
      iy_q      <= iy_d;
      iz_q      <= iz_d;
    end
  end

endmodule

### sv/vgm_queue.sv
// ----------------------------------------------------------------------------
// vgm_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module vgm_queue import vgm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int PtrW = $clog2(QDepth);

  cmd_t            ent_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = cnt_q == (PtrW+1)'(QDepth);
  assign valid_o = cnt_q != '0;
  assign head_o  = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + PtrW'(1);
      if (pop_i) rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

### sv/vgm_back.sv
// ----------------------------------------------------------------------------
// vgm_back
// window memory, neighbor reads, squared differences, square root and bounds
// ----------------------------------------------------------------------------
module vgm_back import vgm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      restart_i,
  input  logic                      q_valid_i,
  input  cmd_t                      q_head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] value_o,
  output logic [GradW-1:0]          gradient_o,
  output logic                      last_voxel_o,
  output logic signed [SampleW-1:0] value_min_o,
  output logic signed [SampleW-1:0] value_max_o,
  output logic [GradW-1:0]          gradient_min_o,
  output logic [GradW-1:0]          gradient_max_o
);

  localparam int NumRd = 7;
  localparam int KW    = 3;
  localparam int ItW   = $clog2(GradW);
  localparam logic signed [SampleW-1:0] VMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] VMin = {1'b1, {(SampleW-1){1'b0}}};

  back_state_e state_q, state_d;

  logic [SizeW-1:0] nx, ny, nz;
  logic [KW-1:0]    k_q, k_d;
  logic [1:0]       axis_q, axis_d;
  logic [ItW-1:0]   it_q, it_d;
  logic [DimW-1:0]  ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic [ZW-1:0]    oz5_q, oz5_d;
  logic             last_q, last_d;
  logic signed [SampleW-1:0] rd_q [NumRd];
  logic [SumW-1:0]  sum_q, sum_d, rad_q, rad_d;
  logic [RemW-1:0]  rem_q, rem_d, rem_sh, trial;
  logic [GradW-1:0] root_q, root_d;

  logic signed [SampleW-1:0] rvmin_q, rvmin_d, rvmax_q, rvmax_d;
  logic [GradW-1:0]          rgmin_q, rgmin_d, rgmax_q, rgmax_d;
  logic                      ov_q, ov_d;
  logic signed [SampleW-1:0] val_q, val_d, vmin_q, vmin_d, vmax_q, vmax_d;
  logic [GradW-1:0]          grad_q, grad_d, gmin_q, gmin_d, gmax_q, gmax_d;
  logic                      lastv_q, lastv_d;

  logic x_first, x_last, y_first, y_last, z_first, z_last;
  logic [DimW-1:0] px, mx, py, my;
  logic [ZW-1:0]   pz, mz;
  logic            ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [SampleW-1:0] ram_rdata;
  logic signed [SampleW-1:0] pv, mv;
  logic signed [DiffW-1:0]   diff;
  logic signed [SumW-1:0]    sq;
  logic                      out_free;
  logic                      out_valid_q_w;
  logic signed [SampleW-1:0] nvmin, nvmax;
  logic [GradW-1:0]          ngmin, ngmax;

  assign nx = dim(cfg_i.size_x);
  assign ny = dim(cfg_i.size_y);
  assign nz = dim(cfg_i.size_z);

  assign x_first = ox_q == '0;
  assign x_last  = {1'b0, ox_q} == nx - SizeW'(1);
  assign y_first = oy_q == '0;
  assign y_last  = {1'b0, oy_q} == ny - SizeW'(1);
  assign z_first = oz_q == '0;
  assign z_last  = {1'b0, oz_q} == nz - SizeW'(1);

  assign px = x_first ? DimW'(2) : ox_q + DimW'(1);
  assign mx = x_last ? ox_q - DimW'(2) : ox_q - DimW'(1);
  assign py = y_first ? DimW'(2) : oy_q + DimW'(1);
  assign my = y_last ? oy_q - DimW'(2) : oy_q - DimW'(1);
  assign pz = z_first ? zadd(oz5_q, ZW'(2)) : zadd(oz5_q, ZW'(1));
  assign mz = z_last ? zadd(oz5_q, ZW'(3)) : zadd(oz5_q, ZW'(4));

  assign pop_o    = (state_q == BkIdle) && q_valid_i;
  assign ram_we   = pop_o && q_head_i.wr;
  assign out_free = !out_valid_q_w || out_ready_i;

  assign out_valid_o = out_valid_q_w;

  always_comb begin
    ram_addr = {oz5_q, oy_q, ox_q};
    if (state_q == BkIdle) begin
      ram_addr = q_head_i.addr;
    end else begin
      case (k_q)
        KW'(1):  ram_addr = {oz5_q, oy_q, px};
        KW'(2):  ram_addr = {oz5_q, oy_q, mx};
        KW'(3):  ram_addr = {oz5_q, py, ox_q};
        KW'(4):  ram_addr = {oz5_q, my, ox_q};
        KW'(5):  ram_addr = {pz, oy_q, ox_q};
        KW'(6):  ram_addr = {mz, oy_q, ox_q};
        default: ram_addr = {oz5_q, oy_q, ox_q};
      endcase
    end
  end

  vgm_ram #(
    .Width(SampleW),
    .Depth(WinDepth)
  ) u_win (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(q_head_i.data),
    .rdata_o(ram_rdata)
  );

  // per axis difference, one-sided at the borders
  always_comb begin
    case (axis_q)
      2'd0: begin
        pv = x_last ? rd_q[0] : rd_q[1];
        mv = x_first ? rd_q[0] : rd_q[2];
      end
      2'd1: begin
        pv = y_last ? rd_q[0] : rd_q[3];
        mv = y_first ? rd_q[0] : rd_q[4];
      end
      default: begin
        pv = z_last ? rd_q[0] : rd_q[5];
        mv = z_first ? rd_q[0] : rd_q[6];
      end
    endcase
    diff = DiffW'(pv) - DiffW'(mv);
    sq   = diff * diff;
  end

  assign rem_sh = {rem_q[RemW-3:0], rad_q[SumW-1 -: 2]};
  assign trial  = RemW'({root_q, 2'b01});

  assign nvmin = (rd_q[0] < rvmin_q) ? rd_q[0] : rvmin_q;
  assign nvmax = (rd_q[0] > rvmax_q) ? rd_q[0] : rvmax_q;
  assign ngmin = (root_q < rgmin_q) ? root_q : rgmin_q;
  assign ngmax = (root_q > rgmax_q) ? root_q : rgmax_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BkIdle:   if (q_valid_i && q_head_i.emit) state_d = BkRead;
      BkRead:   if (k_q == KW'(NumRd)) state_d = BkSquare;
      BkSquare: if (axis_q == 2'd2) state_d = BkRoot;
      BkRoot:   if (it_q == ItW'(GradW - 1)) state_d = BkOut;
      BkOut:    if (out_free) state_d = BkIdle;
      default:  state_d = BkIdle;
    endcase
  end

  always_comb begin
    k_d     = k_q;
    axis_d  = axis_q;
    it_d    = it_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    oz_d    = oz_q;
    oz5_d   = oz5_q;
    last_d  = last_q;
    sum_d   = sum_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    rvmin_d = rvmin_q;
    rvmax_d = rvmax_q;
    rgmin_d = rgmin_q;
    rgmax_d = rgmax_q;
    ov_d    = out_valid_q_w && !out_ready_i;
    val_d   = val_q;
    grad_d  = grad_q;
    lastv_d = lastv_q;
    vmin_d  = vmin_q;
    vmax_d  = vmax_q;
    gmin_d  = gmin_q;
    gmax_d  = gmax_q;
    unique case (state_q)
      BkIdle: begin
        k_d    = '0;
        axis_d = '0;
        sum_d  = '0;
        if (pop_o) last_d = q_head_i.last;
      end
      BkRead: begin
        k_d = k_q + KW'(1);
      end
      BkSquare: begin
        axis_d = axis_q + 2'd1;
        sum_d  = sum_q + $unsigned(sq);
        rad_d  = sum_q + $unsigned(sq);
        rem_d  = '0;
        root_d = '0;
        it_d   = '0;
      end
      BkRoot: begin
        it_d  = it_q + ItW'(1);
        rad_d = {rad_q[SumW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[GradW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[GradW-2:0], 1'b0};
        end
      end
      BkOut: begin
        if (out_free) begin
          ov_d    = 1'b1;
          val_d   = rd_q[0];
          grad_d  = root_q;
          lastv_d = last_q;
          if (last_q) begin
            vmin_d  = cfg_i.min_on ? cfg_i.min_val : nvmin;
            vmax_d  = cfg_i.max_on ? cfg_i.max_val : nvmax;
            gmin_d  = ngmin;
            gmax_d  = ngmax;
            rvmin_d = VMax;
            rvmax_d = VMin;
            rgmin_d = '1;
            rgmax_d = '0;
            ox_d    = '0;
            oy_d    = '0;
            oz_d    = '0;
            oz5_d   = '0;
          end else begin
            vmin_d  = '0;
            vmax_d  = '0;
            gmin_d  = '0;
            gmax_d  = '0;
            rvmin_d = nvmin;
            rvmax_d = nvmax;
            rgmin_d = ngmin;
            rgmax_d = ngmax;
            if (x_last) begin
              ox_d = '0;
              if (y_last) begin
                oy_d  = '0;
                oz_d  = oz_q + DimW'(1);
                oz5_d = zadd(oz5_q, ZW'(1));
              end else begin
                oy_d = oy_q + DimW'(1);
              end
            end else begin
              ox_d = ox_q + DimW'(1);
            end
          end
        end
      end
      default: ;
    endcase
    if (restart_i) begin
      rvmin_d = VMax;
      rvmax_d = VMin;
      rgmin_d = '1;
      rgmax_d = '0;
      ox_d    = '0;
      oy_d    = '0;
      oz_d    = '0;
      oz5_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == BkRead && k_q != '0) rd_q[k_q - KW'(1)] <= ram_rdata;
    sum_q  <= sum_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    last_q <= last_d;
    val_q  <= val_d;
    grad_q <= grad_d;
    lastv_q <= lastv_d;
    vmin_q <= vmin_d;
    vmax_q <= vmax_d;
    gmin_q <= gmin_d;
    gmax_q <= gmax_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      k_q     <= '0;
      axis_q  <= '0;
      it_q    <= '0;
      ox_q    <= '0;
      oy_q    <= '0;
      oz_q    <= '0;
      oz5_q   <= '0;
      rvmin_q <= VMax;
      rvmax_q <= VMin;
      rgmin_q <= '1;
      rgmax_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      axis_q  <= axis_d;
      it_q    <= it_d;
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      oz_q    <= oz_d;
      oz5_q   <= oz5_d;
      rvmin_q <= rvmin_d;
      rvmax_q <= rvmax_d;
      rgmin_q <= rgmin_d;
      rgmax_q <= rgmax_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_q_w  = ov_q;
  assign value_o        = val_q;
  assign gradient_o     = grad_q;
  assign last_voxel_o   = lastv_q;
  assign value_min_o    = vmin_q;
  assign value_max_o    = vmax_q;
  assign gradient_min_o = gmin_q;
  assign gradient_max_o = gmax_q;

endmodule

### sv/volume_gradient_magnitude_top.sv
// ----------------------------------------------------------------------------
// volume_gradient_magnitude_top
// streaming 3-d central difference gradient magnitude over a raster volume
// ----------------------------------------------------------------------------
// Samples enter in x, y, z raster order; the word for voxel q leaves once
// sample q plus two slices has arrived, and drain words flush the last two
// slices. A word that writes only (no result) just writes the window memory
// in the back end; a word that gives a result there writes the window memory,
// makes seven reads (the voxel and its six neighbors) through its single port,
// forms the three squared differences on one shared multiplier, runs the
// bit-serial square root, then waits for room and loads the output register.
// A four-entry queue lets the front keep accepting while the back works, until
// the queue is full. The bounds fields carry data only on the last voxel of a volume.
module volume_gradient_magnitude_top import vgm_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CfgIdxW-1:0]        cfg_index_i,
  input  logic [SampleW-1:0]        cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic signed [SampleW-1:0] sample_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] value_o,
  output logic [GradW-1:0]          gradient_o,
  output logic                      last_voxel_o,
  output logic signed [SampleW-1:0] value_min_o,
  output logic signed [SampleW-1:0] value_max_o,
  output logic [GradW-1:0]          gradient_min_o,
  output logic [GradW-1:0]          gradient_max_o
);

  cfg_t cfg_q, cfg_d;
  logic restart;
  logic cfg_we;
  logic push, full, pop, q_valid;
  cmd_t cmd, head;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d   = cfg_q;
    restart = 1'b0;
    if (cfg_we) begin
      unique case (reg_idx_e'(cfg_index_i))
        RegSizeX: begin
          cfg_d.size_x = cfg_data_i[SizeW-1:0];
          restart      = 1'b1;
        end
        RegSizeY: begin
          cfg_d.size_y = cfg_data_i[SizeW-1:0];
          restart      = 1'b1;
        end
        RegSizeZ: begin
          cfg_d.size_z = cfg_data_i[SizeW-1:0];
          restart      = 1'b1;
        end
        RegMinOn:  cfg_d.min_on  = cfg_data_i[0];
        RegMinVal: cfg_d.min_val = cfg_data_i;
        RegMaxOn:  cfg_d.max_on  = cfg_data_i[0];
        RegMaxVal: cfg_d.max_val = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.size_x  <= SizeW'(MaxDim);
      cfg_q.size_y  <= SizeW'(MaxDim);
      cfg_q.size_z  <= SizeW'(MaxDim);
      cfg_q.min_on  <= 1'b0;
      cfg_q.min_val <= '0;
      cfg_q.max_on  <= 1'b0;
      cfg_q.max_val <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  vgm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .restart_i (restart),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .req_type_i(req_type_i),
    .sample_i  (sample_i),
    .full_i    (full),
    .push_o    (push),
    .cmd_o     (cmd)
  );

  vgm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .head_o (head)
  );

  vgm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .restart_i     (restart),
    .q_valid_i     (q_valid),
    .q_head_i      (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .value_o       (value_o),
    .gradient_o    (gradient_o),
    .last_voxel_o  (last_voxel_o),
    .value_min_o   (value_min_o),
    .value_max_o   (value_max_o),
    .gradient_min_o(gradient_min_o),
    .gradient_max_o(gradient_max_o)
  );

endmodule
